// ===== hdl/glpc_pkg.sv =====
// Package for the page-addressed graphic LCD controller.
// Holds geometry constants, instruction codes and the status bit layout.
// Depends on nothing; used by graphic_lcd_page_controller.
`default_nettype none

package glpc_pkg;

   // Geometry of one half of the display.
   localparam int PAGES            = 8;
   localparam int COLUMNS_PER_HALF = 64;
   localparam int HALVES           = 2;
   localparam int PAGE_W           = $clog2(PAGES);
   localparam int COL_W            = $clog2(COLUMNS_PER_HALF);
   localparam int ADDR_W           = PAGE_W + COL_W;
   localparam int HALF_DEPTH       = PAGES * COLUMNS_PER_HALF;
   localparam int BYTE_W           = 8;

   // Half indexes.
   localparam int HALF_LEFT  = 0;
   localparam int HALF_RIGHT = 1;

   // Instruction codes and the masks that select their opcode bits.
   localparam logic [BYTE_W-1:0] OP_ONOFF      = 8'b0011_1110;
   localparam logic [BYTE_W-1:0] OP_ONOFF_MASK = 8'b1111_1110;
   localparam logic [BYTE_W-1:0] OP_PAGE       = 8'b1011_1000;
   localparam logic [BYTE_W-1:0] OP_PAGE_MASK  = 8'b1111_1000;
   localparam logic [BYTE_W-1:0] OP_COLUMN     = 8'b0100_0000;
   localparam logic [BYTE_W-1:0] OP_COLUMN_MASK = 8'b1100_0000;

   // Status byte with the display-off flag set.
   localparam logic [BYTE_W-1:0] STATUS_OFF = 8'b0010_0000;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [BYTE_W-1:0] byte_type;

endpackage : glpc_pkg

`default_nettype wire

// ===== hdl/glpc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data updates only when a read is enabled and holds otherwise.
// Depends on nothing.
`default_nettype none

module glpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : glpc_ram

`default_nettype wire

// ===== hdl/graphic_lcd_page_controller.sv =====
// Page-addressed graphic LCD controller: top level.
// Uses glpc_pkg for constants and glpc_ram for the display memory of each half.
//
// Usage:
//   Each item on the req_ channel is one bus access: chip selects for the left
//   and right halves, a data/instruction flag, a read/write flag and a byte.
//   Each accepted item produces exactly one item on the rsp_ channel, carrying
//   the read byte (status or previously latched data) and a flag that says
//   whether it is read data. Writes return zero with the flag clear.
//   rsp_valid rises in the cycle after acceptance. One item is taken per
//   cycle while req_ready is high; every access kind issues at most one memory
//   operation per half, so the memory port of each half sets that rate.
//   A data read returns the byte latched by the previous data read of that
//   half; the latch is the registered read port of that half's memory, so the
//   fresh byte is fetched in the same cycle the old one is handed out.
//   After reset the block sweeps every address of both memories to zero, one
//   address per cycle, with req_ready low. Pointers, latches and display flags
//   clear at once.
//   The result sits in an output register; while it waits, req_ready stays
//   high only if rsp_ready is high, so a stalled receiver holds off input.
`default_nettype none

module graphic_lcd_page_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_select_left,
   input  wire logic                  req_select_right,
   input  wire logic                  req_is_data,
   input  wire logic                  req_is_read,
   input  wire logic [7:0]            req_bus_in,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [7:0]            rsp_bus_out,
   output      logic                  rsp_bus_valid
);

   import glpc_pkg::*;

   // Control state.
   logic                  clearing_ff, clearing_in;
   addr_type              clear_addr_ff, clear_addr_in;
   logic [PAGE_W-1:0]     page_ff [HALVES];
   logic [PAGE_W-1:0]     page_in [HALVES];
   logic [COL_W-1:0]      col_ff [HALVES];
   logic [COL_W-1:0]      col_in [HALVES];
   logic [HALVES-1:0]     enabled_ff, enabled_in;
   logic [HALVES-1:0]     loaded_ff, loaded_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              rsp_bus_out_ff, rsp_bus_out_in;
   logic                  rsp_bus_valid_ff, rsp_bus_valid_in;

   // Memory ports, one set per half.
   logic [HALVES-1:0]     ram_wr_en;
   addr_type              ram_wr_addr [HALVES];
   byte_type              ram_wr_data [HALVES];
   logic [HALVES-1:0]     ram_rd_en;
   addr_type              ram_rd_addr [HALVES];
   byte_type              ram_rd_data [HALVES];

   logic                  accept;
   logic [HALVES-1:0]     sel;
   byte_type              half_value [HALVES];

   assign req_ready = !clearing_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign sel[HALF_LEFT]  = req_select_left;
   assign sel[HALF_RIGHT] = req_select_right;

   // Per-half pointer updates, memory access and read value.
   always_comb begin
      for (int h = 0; h < HALVES; h++) begin
         page_in[h]    = page_ff[h];
         col_in[h]     = col_ff[h];
         enabled_in[h] = enabled_ff[h];
         loaded_in[h]  = loaded_ff[h];

         ram_wr_en[h]   = clearing_ff;
         ram_wr_addr[h] = clearing_ff ? clear_addr_ff : {page_ff[h], col_ff[h]};
         ram_wr_data[h] = clearing_ff ? '0 : req_bus_in;
         ram_rd_en[h]   = 1'b0;
         ram_rd_addr[h] = {page_ff[h], col_ff[h]};

         if (accept && sel[h]) begin
            if (req_is_data) begin
               // Data access: write or fetch at the pointer, then advance.
               col_in[h] = col_ff[h] + 1'b1;
               if (req_is_read) begin
                  ram_rd_en[h] = 1'b1;
                  loaded_in[h] = 1'b1;
               end else begin
                  ram_wr_en[h] = 1'b1;
               end
            end else if (!req_is_read) begin
               // Instruction decode; unknown codes are ignored.
               priority if ((req_bus_in & OP_ONOFF_MASK) == OP_ONOFF) begin
                  enabled_in[h] = req_bus_in[0];
               end else if ((req_bus_in & OP_PAGE_MASK) == OP_PAGE) begin
                  page_in[h] = req_bus_in[PAGE_W-1:0];
               end else if ((req_bus_in & OP_COLUMN_MASK) == OP_COLUMN) begin
                  col_in[h] = req_bus_in[COL_W-1:0];
               end else begin
                  // Start line and every other code leave the state alone.
                  enabled_in[h] = enabled_ff[h];
               end
            end
         end

         // Value a read of this half returns: the latch or the status byte.
         if (req_is_data) begin
            half_value[h] = loaded_ff[h] ? ram_rd_data[h] : '0;
         end else begin
            half_value[h] = enabled_ff[h] ? '0 : STATUS_OFF;
         end
      end
   end

   // Result selection and output register handshake.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_bus_out_in   = rsp_bus_out_ff;
      rsp_bus_valid_in = rsp_bus_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         priority if (req_is_read && req_select_left) begin
            rsp_bus_out_in   = half_value[HALF_LEFT];
            rsp_bus_valid_in = 1'b1;
         end else if (req_is_read && req_select_right) begin
            rsp_bus_out_in   = half_value[HALF_RIGHT];
            rsp_bus_valid_in = 1'b1;
         end else begin
            rsp_bus_out_in   = '0;
            rsp_bus_valid_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Clearing sweep over both memories after reset.
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == addr_type'(HALF_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         enabled_ff    <= '0;
         loaded_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int h = 0; h < HALVES; h++) begin
            page_ff[h] <= '0;
            col_ff[h]  <= '0;
         end
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         enabled_ff    <= enabled_in;
         loaded_ff     <= loaded_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int h = 0; h < HALVES; h++) begin
            page_ff[h] <= page_in[h];
            col_ff[h]  <= col_in[h];
         end
      end
      rsp_bus_out_ff   <= rsp_bus_out_in;
      rsp_bus_valid_ff <= rsp_bus_valid_in;
   end

   // Display memory, one RAM per half.
   for (genvar g = 0; g < HALVES; g++) begin : g_half
      glpc_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (HALF_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en[g]),
         .wr_addr (ram_wr_addr[g]),
         .wr_data (ram_wr_data[g]),
         .rd_en   (ram_rd_en[g]),
         .rd_addr (ram_rd_addr[g]),
         .rd_data (ram_rd_data[g])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bus_out   = rsp_bus_out_ff;
   assign rsp_bus_valid = rsp_bus_valid_ff;

endmodule : graphic_lcd_page_controller

`default_nettype wire
